>>> design/radon_line_weight_mask_defines.svh
// ---------------------------------------------------------------------------
// Radon line weight mask: assertion macros
// Shared property forms for the block's checks; clk and rst_n are implied.
// ---------------------------------------------------------------------------
`ifndef RADON_LINE_WEIGHT_MASK_DEFINES_SVH
`define RADON_LINE_WEIGHT_MASK_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define RLWM_ASSERT_IMPL(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("rlwm: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define RLWM_ASSERT_NEXT(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("rlwm: next-cycle check failed");

`endif

>>> design/rlwm_pkg.sv
// ---------------------------------------------------------------------------
// Radon line weight mask package
// Shared constants, register codes, item structs and the CORDIC angle table.
// ---------------------------------------------------------------------------
package rlwm_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;

    // CORDIC: 28 steps on a 32-bit turn fraction, gain pre-applied in Q30
    localparam int          CORDIC_STEPS = 28;
    localparam int          CORDIC_XW    = 34;
    localparam int          CORDIC_ZW    = 34;
    localparam logic [31:0] CORDIC_GAIN  = 32'd652032874;

    // Quotient bits kept by the divider; anything larger saturates
    localparam int QUOT_W = 33;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [30:0] RESET_TIME_LAST    = 31'd65536;
    localparam logic [30:0] RESET_SPACING      = 31'd65536;
    localparam logic [30:0] RESET_FLOOR_WEIGHT = 31'd65536;

    localparam logic [31:0] WEIGHT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] WEIGHT_MIN = 32'h8000_0000;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_REFERENCE_ANGLE  = 3'd0,
        REG_REFERENCE_OFFSET = 3'd1,
        REG_RADIUS           = 3'd2,
        REG_TIME_FIRST       = 3'd3,
        REG_TIME_LAST        = 3'd4,
        REG_SPACING          = 3'd5,
        REG_FLOOR_WEIGHT     = 3'd6
    } rlwm_reg_t;

    typedef enum logic [1:0] {
        MASK_NONE       = 2'd0,
        MASK_THIRD      = 2'd1,
        MASK_TWO_THIRDS = 2'd2,
        MASK_FULL       = 2'd3
    } rlwm_mask_t;

    // Sideband carried alongside the CORDIC
    typedef struct packed {
        logic signed [31:0] offset;
        logic signed [31:0] length;
    } rlwm_cordic_tag_t;

    // Sideband carried alongside the divider
    typedef struct packed {
        rlwm_mask_t code;
        logic       den_neg;
        logic       den_zero;
        logic       top_nz;
    } rlwm_div_tag_t;

    // atan(2^-i) as a 32-bit turn fraction
    function automatic logic [31:0] cordic_atan(input int unsigned idx);
        logic [31:0] r;
        case (idx)
            0:  r = 32'd536870912;
            1:  r = 32'd316933406;
            2:  r = 32'd167458907;
            3:  r = 32'd85004756;
            4:  r = 32'd42667331;
            5:  r = 32'd21354465;
            6:  r = 32'd10679838;
            7:  r = 32'd5340245;
            8:  r = 32'd2670163;
            9:  r = 32'd1335087;
            10: r = 32'd667544;
            11: r = 32'd333772;
            12: r = 32'd166886;
            13: r = 32'd83443;
            14: r = 32'd41722;
            15: r = 32'd20861;
            16: r = 32'd10430;
            17: r = 32'd5215;
            18: r = 32'd2608;
            19: r = 32'd1304;
            20: r = 32'd652;
            21: r = 32'd326;
            22: r = 32'd163;
            23: r = 32'd81;
            24: r = 32'd41;
            25: r = 32'd20;
            26: r = 32'd10;
            27: r = 32'd5;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

>>> design/rlwm_cordic.sv
// ---------------------------------------------------------------------------
// Radon line weight mask: pipelined CORDIC
// Sine and cosine of a binary angle, one rotation step per register stage.
// ---------------------------------------------------------------------------
module rlwm_cordic #(
    parameter int ANGLE_BITS = rlwm_pkg::ANGLE_BITS_DEF,
    parameter int FRAC_BITS  = rlwm_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [ANGLE_BITS-1:0]         delta,
    input  rlwm_pkg::rlwm_cordic_tag_t    in_tag,
    output logic                          out_valid,
    output logic signed [FRAC_BITS+1:0]   sine,
    output logic signed [FRAC_BITS+1:0]   cosine,
    output rlwm_pkg::rlwm_cordic_tag_t    out_tag
);

    localparam int STEPS = rlwm_pkg::CORDIC_STEPS;
    localparam int XW    = rlwm_pkg::CORDIC_XW;
    localparam int ZW    = rlwm_pkg::CORDIC_ZW;
    localparam logic signed [XW:0] RND = (XW+1)'(1) << (29 - FRAC_BITS);
    localparam logic signed [XW:0] ONE = (XW+1)'(1) << FRAC_BITS;

    logic signed [XW-1:0]       x_reg    [0:STEPS];
    logic signed [XW-1:0]       y_reg    [0:STEPS];
    logic signed [ZW-1:0]       z_reg    [0:STEPS];
    logic                       flip_reg [0:STEPS];
    logic                       valid_reg[0:STEPS];
    rlwm_pkg::rlwm_cordic_tag_t tag_reg  [0:STEPS];

    logic [31:0] u_raw;
    logic [31:0] u_quarter;
    logic [31:0] u_rot;
    logic        flip_next;

    // Reduce the angle to within a quarter turn either side of zero
    always_comb
    begin
        u_raw     = {delta, {(32-ANGLE_BITS){1'b0}}};
        u_quarter = u_raw + 32'h4000_0000;
        flip_next = u_quarter[31];
        u_rot     = flip_next ? (u_raw - 32'h8000_0000) : u_raw;
    end

    // Hold the entry stage valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg[0] <= 1'b0;
        else if (en)
            valid_reg[0] <= in_valid;
    end

    // Load the entry stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= $signed({{(XW-32){1'b0}}, rlwm_pkg::CORDIC_GAIN});
            y_reg[0]    <= '0;
            z_reg[0]    <= $signed({{(ZW-32){u_rot[31]}}, u_rot});
            flip_reg[0] <= flip_next;
            tag_reg[0]  <= in_tag;
        end
    end

    // One rotation per stage
    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        logic signed [XW-1:0] xs;
        logic signed [XW-1:0] ys;
        logic signed [ZW-1:0] at;
        logic signed [XW-1:0] x_next;
        logic signed [XW-1:0] y_next;
        logic signed [ZW-1:0] z_next;

        always_comb
        begin
            xs = x_reg[i] >>> i;
            ys = y_reg[i] >>> i;
            at = $signed({{(ZW-32){1'b0}}, rlwm_pkg::cordic_atan(i)});
            if (!z_reg[i][ZW-1])
            begin
                x_next = x_reg[i] - ys;
                y_next = y_reg[i] + xs;
                z_next = z_reg[i] - at;
            end
            else
            begin
                x_next = x_reg[i] + ys;
                y_next = y_reg[i] - xs;
                z_next = z_reg[i] + at;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i+1] <= 1'b0;
            else if (en)
                valid_reg[i+1] <= valid_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i+1]    <= x_next;
                y_reg[i+1]    <= y_next;
                z_reg[i+1]    <= z_next;
                flip_reg[i+1] <= flip_reg[i];
                tag_reg[i+1]  <= tag_reg[i];
            end
        end
    end

    logic signed [XW:0]        xv, yv, xr, yr;
    logic signed [FRAC_BITS+1:0] cos_next, sin_next;
    logic                      out_valid_reg;
    logic signed [FRAC_BITS+1:0] sine_reg, cosine_reg;
    rlwm_pkg::rlwm_cordic_tag_t out_tag_reg;

    // Undo the half-turn flip, round to the fraction width and clamp to one
    always_comb
    begin
        xv = {x_reg[STEPS][XW-1], x_reg[STEPS]};
        yv = {y_reg[STEPS][XW-1], y_reg[STEPS]};
        if (flip_reg[STEPS])
        begin
            xv = -xv;
            yv = -yv;
        end
        xr = (xv + RND) >>> (30 - FRAC_BITS);
        yr = (yv + RND) >>> (30 - FRAC_BITS);
        if (xr > ONE)
            xr = ONE;
        else if (xr < -ONE)
            xr = -ONE;
        if (yr > ONE)
            yr = ONE;
        else if (yr < -ONE)
            yr = -ONE;
        cos_next = xr[FRAC_BITS+1:0];
        sin_next = yr[FRAC_BITS+1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= valid_reg[STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sine_reg    <= sin_next;
            cosine_reg  <= cos_next;
            out_tag_reg <= tag_reg[STEPS];
        end
    end

    assign out_valid = out_valid_reg;
    assign sine      = sine_reg;
    assign cosine    = cosine_reg;
    assign out_tag   = out_tag_reg;

endmodule

>>> design/rlwm_div.sv
// ---------------------------------------------------------------------------
// Radon line weight mask: pipelined divider
// Restoring unsigned division, one quotient bit per stage, with overflow flag.
// ---------------------------------------------------------------------------
module rlwm_div #(
    parameter int DIVISOR_W = 54
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic [63:0]                        dividend,
    input  logic [DIVISOR_W-1:0]               divisor,
    input  rlwm_pkg::rlwm_div_tag_t            in_tag,
    output logic                               out_valid,
    output logic [rlwm_pkg::QUOT_W-1:0]        quotient,
    output logic                               over,
    output rlwm_pkg::rlwm_div_tag_t            out_tag
);

    localparam int QW = rlwm_pkg::QUOT_W;
    localparam int CW = DIVISOR_W + QW;

    logic [63:0]             rem_reg  [0:QW];
    logic [DIVISOR_W-1:0]    dvs_reg  [0:QW];
    logic [QW-1:0]           q_reg    [0:QW];
    logic                    over_reg [0:QW];
    logic                    valid_reg[0:QW];
    rlwm_pkg::rlwm_div_tag_t tag_reg  [0:QW];

    logic over_next;

    // Flag a quotient too wide for the kept bits
    assign over_next = CW'(dividend) >= (CW'(divisor) << QW);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg[0] <= 1'b0;
        else if (en)
            valid_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= dividend;
            dvs_reg[0]  <= divisor;
            q_reg[0]    <= '0;
            over_reg[0] <= over_next;
            tag_reg[0]  <= in_tag;
        end
    end

    // One trial subtraction per stage, most significant bit first
    for (genvar k = 1; k <= QW; k++)
    begin : g_bit
        localparam int B = QW - k;
        logic [CW-1:0] trial;
        logic [CW-1:0] remx;
        logic          ge;
        logic [63:0]   rem_next;
        logic [QW-1:0] q_next;

        always_comb
        begin
            trial    = CW'(dvs_reg[k-1]) << B;
            remx     = CW'(rem_reg[k-1]);
            ge       = remx >= trial;
            rem_next = ge ? 64'(remx - trial) : rem_reg[k-1];
            q_next   = q_reg[k-1] | (ge ? (QW'(1) << B) : '0);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (en)
                valid_reg[k] <= valid_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                dvs_reg[k]  <= dvs_reg[k-1];
                q_reg[k]    <= q_next;
                over_reg[k] <= over_reg[k-1];
                tag_reg[k]  <= tag_reg[k-1];
            end
        end
    end

    assign out_valid = valid_reg[QW];
    assign quotient  = q_reg[QW];
    assign over      = over_reg[QW];
    assign out_tag   = tag_reg[QW];

endmodule

>>> design/radon_line_weight_mask.sv
// Pipeline: 30 CORDIC stages, 5 arithmetic stages, 34 divider stages and 1 output
// stage lie between an accepted input item and its result item.
// Throughput: one item per cycle; the whole pipeline advances together and
// halts only while the output register holds an item that is not taken.
// Reset: rst_n clears all valid bits and loads the register reset values;
// derived configuration terms are registered and follow each write through tmag_reg, tthird_reg and t_reg.
// ---------------------------------------------------------------------------
// Radon line weight mask
// Per-sample region mask and weighted line value in Radon space.
// ---------------------------------------------------------------------------
`include "radon_line_weight_mask_defines.svh"

module radon_line_weight_mask #(
    parameter int ANGLE_BITS = rlwm_pkg::ANGLE_BITS_DEF,
    parameter int FRAC_BITS  = rlwm_pkg::FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [rlwm_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [rlwm_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // angle [ANGLE_BITS], offset [32], length [32], zero fill
    input  logic [((ANGLE_BITS+64+7)/8)*8-1:0]    s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // weight [32], mask_code [2], zero fill [6]
    output logic [39:0]                           m_axis_tdata,
    // saturated [1]
    output logic                                  m_axis_tuser
);

    localparam int F      = FRAC_BITS;
    localparam int SN_W   = F + 2;
    localparam int SH_W   = 64 - F;
    localparam int SOC_W  = SH_W + SN_W;
    localparam int NUM_W  = SH_W + 4;
    localparam int A_W    = SH_W + 1;
    localparam int AA_W   = A_W + F + 2;
    localparam int DEN_W  = A_W + 3;
    localparam int MAG_W  = DEN_W + 2;
    localparam int QW     = rlwm_pkg::QUOT_W;

    // ---------------- configuration registers ----------------
    logic [ANGLE_BITS-1:0] ref_angle_reg;
    logic signed [31:0]    ref_offset_reg;
    logic [15:0]           radius_reg;
    logic [30:0]           time_first_reg;
    logic [30:0]           time_last_reg;
    logic [30:0]           spacing_reg;
    logic [30:0]           floor_reg;

    assign cfg_ready = 1'b1;

    // Take register writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_angle_reg  <= '0;
            ref_offset_reg <= '0;
            radius_reg     <= '0;
            time_first_reg <= '0;
            time_last_reg  <= rlwm_pkg::RESET_TIME_LAST;
            spacing_reg    <= rlwm_pkg::RESET_SPACING;
            floor_reg      <= rlwm_pkg::RESET_FLOOR_WEIGHT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (rlwm_pkg::rlwm_reg_t'(cfg_index))
                rlwm_pkg::REG_REFERENCE_ANGLE:  ref_angle_reg  <= cfg_data[ANGLE_BITS-1:0];
                rlwm_pkg::REG_REFERENCE_OFFSET: ref_offset_reg <= $signed(cfg_data);
                rlwm_pkg::REG_RADIUS:           radius_reg     <= cfg_data[15:0];
                rlwm_pkg::REG_TIME_FIRST:       time_first_reg <= cfg_data[30:0];
                rlwm_pkg::REG_TIME_LAST:        time_last_reg  <= cfg_data[30:0];
                rlwm_pkg::REG_SPACING:          spacing_reg    <= cfg_data[30:0];
                rlwm_pkg::REG_FLOOR_WEIGHT:     floor_reg      <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // ---------------- derived configuration terms ----------------
    logic signed [63:0]     s0sq_full;
    logic signed [SH_W-1:0] s0sq_reg;
    logic [31:0]            rsq_reg;
    logic [61:0]            dp1_reg;
    logic [63:0]            dp3_reg;
    logic signed [31:0]     tdiff;
    logic                   tneg_reg;
    logic [31:0]            tmag_reg;
    logic [63:0]            tthird_full;
    logic [30:0]            tthird_reg;
    logic [31:0]            trem;
    logic [31:0]            ttwo;
    logic [30:0]            t1_next, t2_next;
    logic [30:0]            t_reg [0:3];

    always_comb
    begin
        s0sq_full   = ref_offset_reg * ref_offset_reg;
        tdiff       = $signed({1'b0, time_last_reg}) - $signed({1'b0, time_first_reg});
        tthird_full = 64'(tmag_reg) * 64'h0000_0000_AAAA_AAAB;
        trem        = tmag_reg - {tthird_reg, 1'b0} - 32'(tthird_reg);
        ttwo        = {tthird_reg, 1'b0} + ((trem == 32'd2) ? 32'd1 : 32'd0);
        t1_next     = tneg_reg ? (time_first_reg - tthird_reg)
                               : (time_first_reg + tthird_reg);
        t2_next     = tneg_reg ? (time_first_reg - ttwo[30:0])
                               : (time_first_reg + ttwo[30:0]);
    end

    // Recompute constant terms each cycle from the current configuration registers
    always_ff @(posedge clk)
    begin
        s0sq_reg   <= s0sq_full[63:F];
        rsq_reg    <= radius_reg * radius_reg;
        dp1_reg    <= spacing_reg * floor_reg;
        dp3_reg    <= {2'b00, dp1_reg} + {1'b0, dp1_reg, 1'b0};
        tneg_reg   <= tdiff[31];
        tmag_reg   <= tdiff[31] ? 32'(-tdiff) : 32'(tdiff);
        tthird_reg <= tthird_full[63:33];
        t_reg[0]   <= time_first_reg;
        t_reg[1]   <= t1_next;
        t_reg[2]   <= t2_next;
        t_reg[3]   <= time_last_reg;
    end

    // ---------------- pipeline control ----------------
    logic out_valid_reg;
    logic en;

    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    // ---------------- CORDIC ----------------
    logic [ANGLE_BITS-1:0]      in_angle;
    logic [ANGLE_BITS-1:0]      delta;
    rlwm_pkg::rlwm_cordic_tag_t in_tag;
    logic                       cor_valid;
    logic signed [SN_W-1:0]     cor_sin, cor_cos;
    rlwm_pkg::rlwm_cordic_tag_t cor_tag;

    assign in_angle      = s_axis_tdata[ANGLE_BITS-1:0];
    assign in_tag.offset = $signed(s_axis_tdata[ANGLE_BITS+31:ANGLE_BITS]);
    assign in_tag.length = $signed(s_axis_tdata[ANGLE_BITS+63:ANGLE_BITS+32]);
    assign delta         = in_angle - ref_angle_reg;

    rlwm_cordic #(
        .ANGLE_BITS (ANGLE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .delta     (delta),
        .in_tag    (in_tag),
        .out_valid (cor_valid),
        .sine      (cor_sin),
        .cosine    (cor_cos),
        .out_tag   (cor_tag)
    );

    // ---------------- stage 1: first products ----------------
    logic                   p1_valid_reg;
    logic signed [63:0]     p1_ss_reg, p1_so_reg, p1_sl_reg;
    logic signed [2*SN_W-1:0] p1_sn2_reg;
    logic [F:0]             p1_asn_reg;
    logic signed [SN_W-1:0] p1_cs_reg;
    logic signed [SN_W-1:0] abs_sin;

    assign abs_sin = cor_sin[SN_W-1] ? -cor_sin : cor_sin;

    // ---------------- stage 2 ----------------
    logic                   p2_valid_reg;
    logic signed [SH_W-1:0] p2_ss_reg;
    logic signed [SOC_W-1:0] p2_soc_reg;
    logic signed [A_W-1:0]  p2_a_reg;
    logic [F:0]             p2_asn_reg;
    logic [F:0]             p2_sin2_reg;

    // ---------------- stage 3 ----------------
    logic                   p3_valid_reg;
    logic signed [NUM_W-1:0] p3_num_reg;
    logic signed [AA_W-1:0] p3_aa_reg;
    logic [F:0]             p3_sin2_reg;
    logic signed [NUM_W-1:0] num_next;

    always_comb
    begin
        num_next = NUM_W'(p2_ss_reg) + NUM_W'(s0sq_reg)
                 - (NUM_W'($signed(p2_soc_reg[SOC_W-1:F])) <<< 1);
    end

    // ---------------- stage 4 ----------------
    logic                   p4_valid_reg;
    logic signed [NUM_W-1:0] p4_num_reg;
    logic [63:0]            p4_rhs_reg [0:3];
    logic signed [DEN_W-1:0] p4_den_reg;

    // ---------------- stage 5 ----------------
    logic                   p5_valid_reg;
    rlwm_pkg::rlwm_mask_t   p5_code_reg;
    logic                   p5_den_neg_reg, p5_den_zero_reg;
    logic [MAG_W-1:0]       p5_mag_reg;
    logic [3:0]             lt, gt;
    rlwm_pkg::rlwm_mask_t   code_next;
    logic [DEN_W-1:0]       abs_den;
    logic [MAG_W-1:0]       mag_next;

    // Sign of numerator minus R^2 * (sin^2 + t) at each time
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (p4_num_reg[NUM_W-1])
            begin
                lt[i] = 1'b1;
                gt[i] = 1'b0;
            end
            else
            begin
                lt[i] = 64'(unsigned'(p4_num_reg)) < p4_rhs_reg[i];
                gt[i] = 64'(unsigned'(p4_num_reg)) > p4_rhs_reg[i];
            end
        end
        code_next = rlwm_pkg::MASK_NONE;
        if (lt[0])
            code_next = rlwm_pkg::MASK_FULL;
        if (gt[0] && lt[1])
            code_next = rlwm_pkg::MASK_FULL;
        if (gt[1] && lt[2])
            code_next = rlwm_pkg::MASK_TWO_THIRDS;
        if (gt[2] && lt[3])
            code_next = rlwm_pkg::MASK_THIRD;
        abs_den  = p4_den_reg[DEN_W-1] ? DEN_W'(-p4_den_reg) : DEN_W'(p4_den_reg);
        mag_next = MAG_W'(abs_den) + (MAG_W'(abs_den) << 1);
    end

    // Advance the arithmetic stages together
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
            p5_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_valid_reg <= cor_valid;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg;
            p5_valid_reg <= p4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_ss_reg   <= cor_tag.offset * cor_tag.offset;
            p1_so_reg   <= cor_tag.offset * ref_offset_reg;
            p1_sl_reg   <= $signed({1'b0, spacing_reg}) * cor_tag.length;
            p1_sn2_reg  <= cor_sin * cor_sin;
            p1_asn_reg  <= abs_sin[F:0];
            p1_cs_reg   <= cor_cos;

            p2_ss_reg   <= p1_ss_reg[63:F];
            p2_soc_reg  <= $signed(p1_so_reg[63:F]) * p1_cs_reg;
            p2_a_reg    <= A_W'($signed(p1_sl_reg[63:F])) - $signed({{(A_W-31){1'b0}}, floor_reg});
            p2_asn_reg  <= p1_asn_reg;
            p2_sin2_reg <= p1_sn2_reg[2*F:F];

            p3_num_reg  <= num_next;
            p3_aa_reg   <= p2_a_reg * $signed({1'b0, p2_asn_reg});
            p3_sin2_reg <= p2_sin2_reg;

            p4_num_reg  <= p3_num_reg;
            for (int i = 0; i < 4; i++)
                p4_rhs_reg[i] <= rsq_reg * (32'(p3_sin2_reg) + 32'(t_reg[i]));
            p4_den_reg  <= DEN_W'($signed(p3_aa_reg[AA_W-1:F]))
                         + $signed({{(DEN_W-31){1'b0}}, floor_reg});

            p5_code_reg     <= code_next;
            p5_den_neg_reg  <= p4_den_reg[DEN_W-1];
            p5_den_zero_reg <= (p4_den_reg == '0);
            p5_mag_reg      <= mag_next;
        end
    end

    // ---------------- divider ----------------
    logic [63:0]             top;
    rlwm_pkg::rlwm_div_tag_t div_in_tag;
    logic                    div_valid;
    logic [QW-1:0]           div_q;
    logic                    div_over;
    rlwm_pkg::rlwm_div_tag_t div_tag;

    // Select numerator d*p_min times the mask code
    always_comb
    begin
        case (p5_code_reg)
            rlwm_pkg::MASK_THIRD:      top = {2'b00, dp1_reg};
            rlwm_pkg::MASK_TWO_THIRDS: top = {1'b0, dp1_reg, 1'b0};
            rlwm_pkg::MASK_FULL:       top = dp3_reg;
            default:                   top = '0;
        endcase
        div_in_tag.code     = p5_code_reg;
        div_in_tag.den_neg  = p5_den_neg_reg;
        div_in_tag.den_zero = p5_den_zero_reg;
        div_in_tag.top_nz   = (dp1_reg != '0);
    end

    rlwm_div #(
        .DIVISOR_W (MAG_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p5_valid_reg),
        .dividend  (top),
        .divisor   (p5_mag_reg),
        .in_tag    (div_in_tag),
        .out_valid (div_valid),
        .quotient  (div_q),
        .over      (div_over),
        .out_tag   (div_tag)
    );

    // ---------------- output stage ----------------
    logic [31:0]          weight_next;
    logic                 sat_next;
    logic [31:0]          out_weight_reg;
    rlwm_pkg::rlwm_mask_t out_code_reg;
    logic                 out_sat_reg;
    logic [QW-1:0]        neg_q;

    // Apply sign and saturate
    always_comb
    begin
        neg_q       = -div_q;
        weight_next = '0;
        sat_next    = 1'b0;
        if (div_tag.code == rlwm_pkg::MASK_NONE)
        begin
            weight_next = '0;
            sat_next    = 1'b0;
        end
        else if (div_tag.den_zero)
        begin
            sat_next    = 1'b1;
            weight_next = div_tag.top_nz ? rlwm_pkg::WEIGHT_MAX : '0;
        end
        else if (!div_tag.den_neg)
        begin
            if (div_over || (div_q > QW'(rlwm_pkg::WEIGHT_MAX)))
            begin
                sat_next    = 1'b1;
                weight_next = rlwm_pkg::WEIGHT_MAX;
            end
            else
                weight_next = div_q[31:0];
        end
        else
        begin
            if (div_over || (div_q > QW'(rlwm_pkg::WEIGHT_MIN)))
            begin
                sat_next    = 1'b1;
                weight_next = rlwm_pkg::WEIGHT_MIN;
            end
            else
                weight_next = neg_q[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= div_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_weight_reg <= weight_next;
            out_code_reg   <= div_tag.code;
            out_sat_reg    <= sat_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b000000, out_code_reg, out_weight_reg};
    assign m_axis_tuser  = out_sat_reg;

    // ---------------- checks ----------------
    `RLWM_ASSERT_IMPL(a_empty_mask_zero, m_axis_tvalid && (out_code_reg == rlwm_pkg::MASK_NONE), (out_weight_reg == '0) && !out_sat_reg)
    `RLWM_ASSERT_IMPL(a_sat_limits, m_axis_tvalid && out_sat_reg, (out_weight_reg == rlwm_pkg::WEIGHT_MAX) || (out_weight_reg == rlwm_pkg::WEIGHT_MIN) || (out_weight_reg == '0))
    `RLWM_ASSERT_NEXT(a_stall_holds_pipe, !en, $stable(p5_valid_reg) && $stable(p5_code_reg))

endmodule
